>>> rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// shared types and constants of the sorted term accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int EXP_BITS      = 8;
    localparam int COEFF_BITS    = 32;
    localparam int IN_POWERS     = 4;
    localparam int TOL_BITS      = 31;
    localparam int VC_BITS       = 3;
    localparam int RIDX_BITS     = 6;
    localparam int POS_BITS      = 7;
    localparam int DEF_MAX_TERMS = 64;
    localparam int DEF_MAX_VARS  = 4;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_INSERTED = 3'd1,
        ST_MERGED   = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_READ_BAD = 3'd5,
        ST_FULL     = 3'd6,
        ST_CLEARED  = 3'd7
    } t_status;

    typedef enum logic {
        CFG_VAR_COUNT = 1'b0,
        CFG_TOLERANCE = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_UPD
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_MERGE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic [COEFF_BITS-1:0]   coeff;
    } t_cell_cmd;

endpackage

`default_nettype wire

>>> rtl/stc_in_if.sv
// ----------------------------------------------------------------------------
// stc_in_if
// request channel of the sorted term accumulator
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_in_if import stc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [EXP_BITS-1:0]   power_0;
    logic [EXP_BITS-1:0]   power_1;
    logic [EXP_BITS-1:0]   power_2;
    logic [EXP_BITS-1:0]   power_3;
    logic [COEFF_BITS-1:0] coeff_in;
    logic [RIDX_BITS-1:0]  read_index;

    modport source (output valid, opcode, power_0, power_1, power_2, power_3,
                    coeff_in, read_index, input ready);
    modport sink   (input valid, opcode, power_0, power_1, power_2, power_3,
                    coeff_in, read_index, output ready);
endinterface

`default_nettype wire

>>> rtl/stc_out_if.sv
// ----------------------------------------------------------------------------
// stc_out_if
// result channel of the sorted term accumulator
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_out_if import stc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic [POS_BITS-1:0]   position;
    logic [COEFF_BITS-1:0] coeff_out;
    logic [EXP_BITS-1:0]   out_power_0;
    logic [EXP_BITS-1:0]   out_power_1;
    logic [EXP_BITS-1:0]   out_power_2;
    logic [EXP_BITS-1:0]   out_power_3;
    logic [POS_BITS-1:0]   term_count;

    modport source (output valid, status, position, coeff_out, out_power_0,
                    out_power_1, out_power_2, out_power_3, term_count,
                    input ready);
    modport sink   (input valid, status, position, coeff_out, out_power_0,
                    out_power_1, out_power_2, out_power_3, term_count,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/stc_cell.sv
// ----------------------------------------------------------------------------
// stc_cell
// one table slot: holds a term, compares it to the request, shifts with its
// neighbors on insert and remove
// ----------------------------------------------------------------------------
`default_nettype none

module stc_cell import stc_pkg::*; #(
    parameter int K        = 0,
    parameter int MAX_VARS = DEF_MAX_VARS,
    parameter int CW       = 7
) (
    input  wire logic                                  i_clk,
    input  wire t_cell_cmd                             i_cmd,
    input  wire logic [CW-1:0]                         i_pos,
    input  wire logic [MAX_VARS-1:0][EXP_BITS-1:0]     i_term,
    input  wire logic [COEFF_BITS-1:0]                 i_prev_coeff,
    input  wire logic [MAX_VARS-1:0][EXP_BITS-1:0]     i_prev_exp,
    input  wire logic [COEFF_BITS-1:0]                 i_next_coeff,
    input  wire logic [MAX_VARS-1:0][EXP_BITS-1:0]     i_next_exp,
    output logic [COEFF_BITS-1:0]                      o_coeff,
    output logic [MAX_VARS-1:0][EXP_BITS-1:0]          o_exp,
    output logic                                       o_lt,
    output logic                                       o_eq
);

    logic [COEFF_BITS-1:0]             r_coeff, n_coeff;
    logic [MAX_VARS-1:0][EXP_BITS-1:0] r_exp, n_exp;
    logic                              done;
    logic [CW-1:0]                     idx;

    assign idx = CW'(K);

    // lexicographic compare, larger exponent first
    always_comb begin
        done = 1'b0;
        o_lt = 1'b0;
        for (int v = 0; v < MAX_VARS; v++) begin
            if (!done && r_exp[v] != i_term[v]) begin
                done = 1'b1;
                o_lt = r_exp[v] > i_term[v];
            end
        end
        o_eq = !done;
    end

    always_comb begin
        n_coeff = r_coeff;
        n_exp   = r_exp;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (idx == i_pos) begin
                    n_coeff = i_cmd.coeff;
                    n_exp   = i_term;
                end else if (idx > i_pos) begin
                    n_coeff = i_prev_coeff;
                    n_exp   = i_prev_exp;
                end
            end
            CELL_REMOVE: begin
                if (idx >= i_pos) begin
                    n_coeff = i_next_coeff;
                    n_exp   = i_next_exp;
                end
            end
            CELL_MERGE: begin
                if (idx == i_pos) begin
                    n_coeff = i_cmd.coeff;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_coeff <= n_coeff;
        r_exp   <= n_exp;
    end

    assign o_coeff = r_coeff;
    assign o_exp   = r_exp;

endmodule

`default_nettype wire

>>> rtl/sorted_term_accumulator.sv
// ----------------------------------------------------------------------------
// sorted_term_accumulator
// sorted polynomial term table built as a row of shifting cells
// ----------------------------------------------------------------------------
// requests arrive on i_in (valid/ready); one transaction: add a term, read a
// slot or clear the table. opcode 3 is consumed without a result.
// every other request gives exactly one transaction on o_out.
// each request steps through accept, compare in all cells at once, select
// the boundary cell through a one-hot mux, then update; the update shifts
// the cells from the slot upward toward or away from their neighbors, or
// rewrites the merged cell in place. a new request is accepted only after
// the previous one leaves the update step. a request is taken while the
// previous result still waits; if the receiver stalls, the update step
// holds until the output register frees up.
// configuration: i_cfg_we with i_cfg_index 0 (variable count, empties the
// table) or 1 (zero tolerance); write only while idle.
// reset empties the table, variable count 1, tolerance 0. no clearing
// pass: slots above the term count are never observed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_term_accumulator import stc_pkg::*; #(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int MAX_VARS  = DEF_MAX_VARS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [TOL_BITS-1:0] i_cfg_data,
    stc_in_if.sink                   i_in,
    stc_out_if.source                o_out
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int XW = (CW > RIDX_BITS) ? CW : RIDX_BITS;

    t_state                            r_state, n_state;
    logic [CW-1:0]                     r_count;
    logic [VC_BITS-1:0]                r_vc;
    logic [TOL_BITS-1:0]               r_tol;
    t_opcode                           r_op;
    logic [MAX_VARS-1:0][EXP_BITS-1:0] r_term, n_term;
    logic [COEFF_BITS-1:0]             r_cin;
    logic [RIDX_BITS-1:0]              r_ridx;
    logic [MAX_TERMS-1:0]              r_sel, n_sel;
    logic                              r_eqsel, n_eqsel;
    logic [COEFF_BITS-1:0]             r_hcoeff, m_coeff;
    logic [MAX_VARS-1:0][EXP_BITS-1:0] r_hexp, m_exp;
    logic [CW-1:0]                     r_pos, m_pos;
    logic                              r_found;

    logic                  r_ov;
    t_status               r_ostatus, n_ostatus;
    logic [CW-1:0]         r_opos, n_opos;
    logic [COEFF_BITS-1:0] r_ocoeff, n_ocoeff;
    logic [IN_POWERS-1:0][EXP_BITS-1:0] r_oexp, n_oexp;
    logic [CW-1:0]         n_count;

    logic                  accept, finish;
    logic [3:0]            act_n;
    logic [EXP_BITS-1:0]   pw_in [IN_POWERS];
    t_cell_cmd             cmd;
    logic [CW-1:0]         slot;

    logic [COEFF_BITS-1:0]             c_coeff [MAX_TERMS];
    logic [MAX_VARS-1:0][EXP_BITS-1:0] c_exp   [MAX_TERMS];
    logic [MAX_TERMS-1:0]              c_lt, c_eq, ahead;

    logic signed [COEFF_BITS:0]   sum;
    logic [COEFF_BITS-1:0]        sat, mag;
    logic                         in_tol;
    logic [IN_POWERS-1:0][EXP_BITS-1:0] hexp_pad, term_pad;

    assign pw_in[0] = i_in.power_0;
    assign pw_in[1] = i_in.power_1;
    assign pw_in[2] = i_in.power_2;
    assign pw_in[3] = i_in.power_3;

    always_comb begin
        if (r_vc == '0) begin
            act_n = 4'd1;
        end else if ({1'b0, r_vc} > 4'(MAX_VARS)) begin
            act_n = 4'(MAX_VARS);
        end else begin
            act_n = {1'b0, r_vc};
        end
    end

    always_comb begin
        for (int v = 0; v < MAX_VARS; v++) begin
            n_term[v] = '0;
            if (v < IN_POWERS && 4'(v) < act_n) begin
                n_term[v] = pw_in[v % IN_POWERS];
            end
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign finish     = (r_state == S_UPD) && (!r_ov || o_out.ready);

    // cell row
    for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
        logic [COEFF_BITS-1:0]             prev_c, next_c;
        logic [MAX_VARS-1:0][EXP_BITS-1:0] prev_e, next_e;
        if (k == 0) begin : g_first
            assign prev_c = '0;
            assign prev_e = '0;
        end else begin : g_mid
            assign prev_c = c_coeff[k-1];
            assign prev_e = c_exp[k-1];
        end
        if (k == MAX_TERMS - 1) begin : g_last
            assign next_c = '0;
            assign next_e = '0;
        end else begin : g_body
            assign next_c = c_coeff[k+1];
            assign next_e = c_exp[k+1];
        end
        stc_cell #(
            .K        (k),
            .MAX_VARS (MAX_VARS),
            .CW       (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_pos        (slot),
            .i_term       (r_term),
            .i_prev_coeff (prev_c),
            .i_prev_exp   (prev_e),
            .i_next_coeff (next_c),
            .i_next_exp   (next_e),
            .o_coeff      (c_coeff[k]),
            .o_exp        (c_exp[k]),
            .o_lt         (c_lt[k]),
            .o_eq         (c_eq[k])
        );
    end

    // boundary detect, or read slot match
    always_comb begin
        for (int k = 0; k < MAX_TERMS; k++) begin
            ahead[k] = (CW'(k) < r_count) && c_lt[k];
        end
        for (int k = 0; k < MAX_TERMS; k++) begin
            if (r_op == OP_READ) begin
                n_sel[k] = (XW'(k) == XW'(r_ridx)) && (CW'(k) < r_count);
            end else if (k == 0) begin
                n_sel[k] = !ahead[k] && (CW'(k) < r_count);
            end else begin
                n_sel[k] = !ahead[k] && ahead[k-1] && (CW'(k) < r_count);
            end
        end
        n_eqsel = |(n_sel & c_eq);
    end

    // one-hot select of the boundary or read entry
    always_comb begin
        m_coeff = '0;
        m_exp   = '0;
        m_pos   = '0;
        for (int k = 0; k < MAX_TERMS; k++) begin
            if (r_sel[k]) begin
                m_coeff = m_coeff | c_coeff[k];
                m_exp   = m_exp | c_exp[k];
                m_pos   = m_pos | CW'(k);
            end
        end
    end

    // merge arithmetic
    always_comb begin
        sum = $signed({r_hcoeff[COEFF_BITS-1], r_hcoeff})
            + $signed({r_cin[COEFF_BITS-1], r_cin});
        if (sum[COEFF_BITS] != sum[COEFF_BITS-1]) begin
            sat = sum[COEFF_BITS] ? {1'b1, {(COEFF_BITS-1){1'b0}}}
                                  : {1'b0, {(COEFF_BITS-1){1'b1}}};
        end else begin
            sat = sum[COEFF_BITS-1:0];
        end
        mag    = sat[COEFF_BITS-1] ? (~sat + 1'b1) : sat;
        in_tol = mag <= COEFF_BITS'(r_tol);
    end

    always_comb begin
        hexp_pad = '0;
        term_pad = '0;
        for (int v = 0; v < MAX_VARS && v < IN_POWERS; v++) begin
            hexp_pad[v] = r_hexp[v];
            term_pad[v] = r_term[v];
        end
    end

    // update decision
    always_comb begin
        cmd.op    = CELL_HOLD;
        cmd.coeff = r_cin;
        slot      = r_found ? r_pos : r_count;
        n_count   = r_count;
        n_ostatus = ST_CLEARED;
        n_opos    = '0;
        n_ocoeff  = '0;
        n_oexp    = '0;
        case (r_op)
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_READ: begin
                n_opos = CW'(r_ridx);
                if (r_found) begin
                    n_ostatus = ST_READ_OK;
                    n_ocoeff  = r_hcoeff;
                    n_oexp    = hexp_pad;
                end else begin
                    n_ostatus = ST_READ_BAD;
                end
            end
            OP_ADD: begin
                n_opos = slot;
                if (r_found && r_eqsel) begin
                    n_ocoeff  = sat;
                    n_oexp    = hexp_pad;
                    cmd.coeff = sat;
                    if (in_tol) begin
                        cmd.op    = CELL_REMOVE;
                        n_count   = r_count - 1'b1;
                        n_ostatus = ST_REMOVED;
                    end else begin
                        cmd.op    = CELL_MERGE;
                        n_ostatus = ST_MERGED;
                    end
                end else if (r_count >= CW'(MAX_TERMS)) begin
                    n_ostatus = ST_FULL;
                    n_ocoeff  = r_cin;
                    n_oexp    = term_pad;
                end else begin
                    cmd.op    = CELL_INSERT;
                    n_count   = r_count + 1'b1;
                    n_ostatus = r_found ? ST_INSERTED : ST_APPENDED;
                    n_ocoeff  = r_cin;
                    n_oexp    = term_pad;
                end
            end
            default: begin
            end
        endcase
        if (!finish) begin
            cmd.op = CELL_HOLD;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && t_opcode'(i_in.opcode) != OP_NONE) n_state = S_CMP;
            S_CMP:  n_state = S_SEL;
            S_SEL:  n_state = S_UPD;
            S_UPD:  if (finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_vc    <= VC_BITS'(1);
            r_tol   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_VAR_COUNT: begin
                        r_vc    <= i_cfg_data[VC_BITS-1:0];
                        r_count <= '0;
                    end
                    CFG_TOLERANCE: r_tol <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (finish) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_opcode'(i_in.opcode);
            r_term <= n_term;
            r_cin  <= i_in.coeff_in;
            r_ridx <= i_in.read_index;
        end
        if (r_state == S_CMP) begin
            r_sel   <= n_sel;
            r_eqsel <= n_eqsel;
        end
        if (r_state == S_SEL) begin
            r_hcoeff <= m_coeff;
            r_hexp   <= m_exp;
            r_pos    <= m_pos;
            r_found  <= |r_sel;
        end
        if (finish) begin
            r_ostatus <= n_ostatus;
            r_opos    <= n_opos;
            r_ocoeff  <= n_ocoeff;
            r_oexp    <= n_oexp;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.status      = r_ostatus;
    assign o_out.position    = POS_BITS'(r_opos);
    assign o_out.coeff_out   = r_ocoeff;
    assign o_out.out_power_0 = r_oexp[0];
    assign o_out.out_power_1 = r_oexp[1];
    assign o_out.out_power_2 = r_oexp[2];
    assign o_out.out_power_3 = r_oexp[3];
    assign o_out.term_count  = POS_BITS'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TERMS))
        else $error("term count above table size");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEL |-> $onehot0(r_sel))
        else $error("more than one boundary cell");

    a_cells_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_UPD |-> cmd.op == CELL_HOLD)
        else $error("cell row moved outside update");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish && r_op == OP_CLEAR |=> r_count == '0 && r_ostatus == ST_CLEARED)
        else $error("clear left terms behind");

endmodule

`default_nettype wire
